FILE: hw/rtl/id3fx_pkg.sv
// shared types and constants of the id3v2 frame extractor
`default_nettype none

package id3fx_pkg;

   // parser phases
   typedef enum logic [2:0] {
      PH_FILEHDR      = 3'd0,
      PH_FRAMEHDR     = 3'd1,
      PH_BODY_PENDING = 3'd2,
      PH_BODY         = 3'd3,
      PH_HALT         = 3'd4
   } phase_type;

   // content decoding chosen by the encoding byte
   typedef enum logic [1:0] {
      TM_LATIN = 2'd0,
      TM_WIDE  = 2'd1,
      TM_RAW   = 2'd2
   } tmode_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_CONTENT = 2'd1,
      KIND_END     = 2'd2,
      KIND_VERSION = 2'd3
   } kind_type;

   // configuration register indexes
   localparam logic CSR_TARGET_ID  = 1'b0;
   localparam logic CSR_REPORT_ALL = 1'b1;

   localparam logic [7:0]  ID3_VERSION     = 8'd3;
   localparam logic [7:0]  ENC_LATIN       = 8'd0;
   localparam logic [7:0]  ENC_WIDE        = 8'd1;
   localparam logic [7:0]  BOM_BYTE        = 8'd101;
   localparam logic [3:0]  SKIP_SHORT      = 4'd3;
   localparam logic [3:0]  SKIP_LONG       = 4'd10;
   localparam logic [31:0] HDR_LAST_BYTE   = 32'd9;
   localparam logic [31:0] FRAME_SHIFT_LEN = 32'd8;
   localparam logic [28:0] POS_MAX         = 29'h1FFF_FFFF;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      kind_type    kind;
      logic [31:0] frame_ident;
      logic [31:0] frame_length;
      logic [7:0]  data_out;
      logic        last;
      logic        found;
   } rec_type;

   // up to two results produced by one byte
   typedef struct packed {
      logic [1:0] count;
      rec_type    first;
      rec_type    second;
   } push_type;

   localparam rec_type REC_ZERO = '{kind: KIND_HEADER, frame_ident: 32'd0,
                                    frame_length: 32'd0, data_out: 8'd0,
                                    last: 1'b0, found: 1'b0};

   // synchsafe size: seven bits from each byte
   function automatic logic [27:0] synchsafe(input logic [31:0] s);
      synchsafe = {s[30:24], s[22:16], s[14:8], s[6:0]};
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/id3fx_front.sv
// byte parser: classifies each byte and produces its results
`default_nettype none

module id3fx_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              file_start,
   input  wire logic [31:0]       target_id,
   input  wire logic              report_all,
   output id3fx_pkg::push_type    push
);
   import id3fx_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [28:0] tag_position_ff, tag_position_in;
   logic [27:0] tag_length_ff, tag_length_in;
   logic [63:0] header_shift_ff, header_shift_in;
   logic [31:0] content_count_ff, content_count_in;
   tmode_type   text_mode_ff, text_mode_in;
   logic [3:0]  skip_offset_ff, skip_offset_in;
   logic        frame_selected_ff, frame_selected_in;
   logic        seen_flag_ff, seen_flag_in;

   // state seen by this byte, after a new-file clear
   phase_type   cur_phase;
   logic [28:0] cur_pos;
   logic [27:0] cur_len;
   logic [63:0] cur_shift;
   logic [31:0] cur_cc;
   tmode_type   cur_tm;
   logic [3:0]  cur_so;
   logic        cur_sel;
   logic        cur_seen;

   logic [63:0] shifted;
   logic [31:0] ident;
   logic [31:0] flen;
   tmode_type   tm_eff;
   logic [3:0]  so_eff;
   logic [32:0] c_plus1;
   logic [32:0] c_plus2;
   logic [31:0] wide_end;
   logic        emit;
   logic        last_byte;
   logic        frame_done;
   logic        pending;
   logic        sel_now;
   rec_type     hdr_rec;
   rec_type     body_rec;
   rec_type     end_rec;
   push_type    push_c;

   always_comb begin
      if (file_start) begin
         cur_phase = PH_FILEHDR;
         cur_pos   = '0;
         cur_len   = '0;
         cur_shift = '0;
         cur_cc    = '0;
         cur_tm    = TM_LATIN;
         cur_so    = '0;
         cur_sel   = 1'b0;
         cur_seen  = 1'b0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = tag_position_ff;
         cur_len   = tag_length_ff;
         cur_shift = header_shift_ff;
         cur_cc    = content_count_ff;
         cur_tm    = text_mode_ff;
         cur_so    = skip_offset_ff;
         cur_sel   = frame_selected_ff;
         cur_seen  = seen_flag_ff;
      end
   end

   // content decode
   always_comb begin
      shifted = {cur_shift[55:0], data_byte};
      ident   = cur_shift[63:32];
      flen    = cur_shift[31:0];

      if (cur_cc == 32'd0) begin
         if (data_byte == ENC_WIDE) begin
            tm_eff = TM_WIDE;
         end else if (data_byte == ENC_LATIN) begin
            tm_eff = TM_LATIN;
         end else begin
            tm_eff = TM_RAW;
         end
         so_eff = SKIP_SHORT;
      end else begin
         tm_eff = cur_tm;
         if (cur_cc == 32'd1 && cur_tm == TM_WIDE && data_byte == BOM_BYTE) begin
            so_eff = SKIP_LONG;
         end else begin
            so_eff = cur_so;
         end
      end

      c_plus1  = {1'b0, cur_cc} + 33'd1;
      c_plus2  = {1'b0, cur_cc} + 33'd2;
      // every other byte from the offset, stopping on a whole pair
      wide_end = flen - {31'd0, flen[0] ^ so_eff[0]};

      case (tm_eff)
         TM_LATIN: begin
            emit      = (cur_cc != 32'd0) && (c_plus2 <= {1'b0, flen});
            last_byte = (c_plus2 == {1'b0, flen});
         end
         TM_WIDE: begin
            emit      = ({1'b0, flen} >= ({29'd0, so_eff} + 33'd2)) &&
                        (cur_cc >= {28'd0, so_eff}) &&
                        (cur_cc[0] == so_eff[0]) &&
                        (cur_cc < wide_end);
            last_byte = emit && (cur_cc == wide_end - 32'd2);
         end
         default: begin
            emit      = 1'b1;
            last_byte = (c_plus1 == {1'b0, flen});
         end
      endcase

      frame_done = (c_plus1 >= {1'b0, flen});
   end

   always_comb begin
      hdr_rec              = REC_ZERO;
      hdr_rec.frame_ident  = ident;
      hdr_rec.frame_length = flen;
      body_rec             = hdr_rec;
      body_rec.kind        = KIND_CONTENT;
      body_rec.data_out    = data_byte;
      body_rec.last        = last_byte;
      end_rec              = REC_ZERO;
      end_rec.kind         = KIND_END;
      end_rec.found        = cur_seen;

      phase_in          = cur_phase;
      tag_position_in   = cur_pos;
      tag_length_in     = cur_len;
      header_shift_in   = cur_shift;
      content_count_in  = cur_cc;
      text_mode_in      = cur_tm;
      skip_offset_in    = cur_so;
      frame_selected_in = cur_sel;
      seen_flag_in      = cur_seen;
      push_c            = '{count: 2'd0, first: REC_ZERO, second: REC_ZERO};
      pending           = 1'b0;
      sel_now           = 1'b0;

      unique case (cur_phase)
         PH_FILEHDR: begin
            header_shift_in = shifted;
            if (cur_cc < HDR_LAST_BYTE) begin
               content_count_in = cur_cc + 32'd1;
            end else begin
               content_count_in = '0;
               if (shifted[55:48] != ID3_VERSION) begin
                  push_c.count      = 2'd1;
                  push_c.first      = REC_ZERO;
                  push_c.first.kind = KIND_VERSION;
                  phase_in          = PH_HALT;
               end else begin
                  tag_length_in   = synchsafe(shifted[31:0]);
                  tag_position_in = '0;
                  header_shift_in = '0;
                  phase_in        = PH_FRAMEHDR;
               end
            end
         end
         PH_FRAMEHDR: begin
            if (cur_cc == 32'd0 &&
                ((cur_pos >= {1'b0, cur_len}) || (!report_all && cur_seen))) begin
               push_c.count = 2'd1;
               push_c.first = end_rec;
               phase_in     = PH_HALT;
            end else begin
               if (cur_pos != POS_MAX) begin
                  tag_position_in = cur_pos + 29'd1;
               end
               if (cur_cc < FRAME_SHIFT_LEN) begin
                  header_shift_in = shifted;
               end
               if (cur_cc < HDR_LAST_BYTE) begin
                  content_count_in = cur_cc + 32'd1;
               end else begin
                  content_count_in = '0;
                  if (flen == 32'd0) begin
                     push_c.count = 2'd1;
                     push_c.first = end_rec;
                     phase_in     = PH_HALT;
                  end else begin
                     sel_now           = report_all || (ident == target_id);
                     frame_selected_in = sel_now;
                     seen_flag_in      = cur_seen | sel_now;
                     phase_in          = sel_now ? PH_BODY_PENDING : PH_BODY;
                  end
               end
            end
         end
         PH_BODY_PENDING, PH_BODY: begin
            if (cur_pos != POS_MAX) begin
               tag_position_in = cur_pos + 29'd1;
            end
            text_mode_in   = tm_eff;
            skip_offset_in = so_eff;
            pending        = (cur_phase == PH_BODY_PENDING);
            if (emit && cur_sel) begin
               if (pending) begin
                  push_c.count  = 2'd2;
                  push_c.first  = hdr_rec;
                  push_c.second = body_rec;
                  pending       = 1'b0;
               end else begin
                  push_c.count = 2'd1;
                  push_c.first = body_rec;
               end
               phase_in = PH_BODY;
            end
            if (frame_done) begin
               // a selected frame with nothing to show still reports its header
               if (pending && cur_sel) begin
                  push_c.count      = 2'd1;
                  push_c.first      = hdr_rec;
                  push_c.first.last = 1'b1;
               end
               phase_in         = PH_FRAMEHDR;
               content_count_in = '0;
               header_shift_in  = '0;
            end else begin
               content_count_in = cur_cc + 32'd1;
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      if (!accept) begin
         push_c.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_FILEHDR;
         tag_position_ff   <= '0;
         tag_length_ff     <= '0;
         header_shift_ff   <= '0;
         content_count_ff  <= '0;
         text_mode_ff      <= TM_LATIN;
         skip_offset_ff    <= '0;
         frame_selected_ff <= 1'b0;
         seen_flag_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff          <= phase_in;
         tag_position_ff   <= tag_position_in;
         tag_length_ff     <= tag_length_in;
         header_shift_ff   <= header_shift_in;
         content_count_ff  <= content_count_in;
         text_mode_ff      <= text_mode_in;
         skip_offset_ff    <= skip_offset_in;
         frame_selected_ff <= frame_selected_in;
         seen_flag_ff      <= seen_flag_in;
      end
   end

   assign push = push_c;

`ifndef SYNTHESIS
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !file_start && phase_ff == PH_HALT) |-> (push.count == 2'd0))
      else $error("halted parser produced a result");

   a_hdr_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FILEHDR) |-> (content_count_ff <= HDR_LAST_BYTE))
      else $error("file header byte count out of range");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/id3fx_queue.sv
// result queue with two-entry push and a registered output stage
`default_nettype none

module id3fx_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire id3fx_pkg::push_type push,
   output logic                   full,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output id3fx_pkg::rec_type     out_rec
);
   import id3fx_pkg::*;

   rec_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                out_valid_ff, out_valid_in;
   rec_type             out_rec_ff;
   logic                pop;
   logic [QPTR_W-1:0]   wr_next;

   assign wr_next = wr_ptr_ff + QPTR_W'(1);
   assign pop     = (count_ff != '0) && (!out_valid_ff || !out_stall);
   // room for two results must be there before a byte is taken
   assign full    = (count_ff > QCNT_W'(QUEUE_DEPTH - 2));

   always_comb begin
      wr_ptr_in    = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in    = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + QCNT_W'(push.count) - QCNT_W'(pop);
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !out_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
      if (pop) begin
         out_rec_ff <= entry_ff[rd_ptr_ff];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rec   = out_rec_ff;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_refill: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && !out_valid_ff) |=> out_valid_ff)
      else $error("queued result not moved to the output stage");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/id3v2_frame_extractor.sv
// top level of the id3v2.3 tag frame extractor
`default_nettype none

// Parses the ID3v2.3 tag at the start of a byte stream, one byte per
// transaction, and reports frame headers, decoded content bytes, an end of
// tag status or a version error. A byte is taken in every cycle while
// req_stall is low: the front parser classifies it combinationally and hands
// its zero, one or two results to a four-entry queue, and the back end
// drains that queue one result per cycle while rsp_stall is low, through a
// registered output. The only byte that makes two results is the first shown
// content byte of a frame, so sustained throughput is one byte per cycle;
// req_stall rises once the queue holds more than two results, which only
// happens while the result side stalls. req_file_start marks the first byte
// of a file and clears the parser before that byte is used. The user must
// write target_id and report_all through the csr_ port while the block is
// idle; the block itself does not enforce this.
module id3v2_frame_extractor (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte input
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_file_start,
   // results
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_frame_ident,
   output logic [31:0]      rsp_frame_length,
   output logic [7:0]       rsp_data_out,
   output logic             rsp_last,
   output logic             rsp_found,
   // configuration
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import id3fx_pkg::*;

   logic [31:0] target_id_ff;
   logic        report_all_ff;
   logic        accept;
   logic        queue_full;
   push_type    push;
   rec_type     out_rec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff  <= '0;
         report_all_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TARGET_ID:  target_id_ff  <= csr_data;
            CSR_REPORT_ALL: report_all_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // a byte transaction completes when the queue has room for two results
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   id3fx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .target_id  (target_id_ff),
      .report_all (report_all_ff),
      .push       (push)
   );

   id3fx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_rec   (out_rec)
   );

   // result fields
   assign rsp_kind         = out_rec.kind;
   assign rsp_frame_ident  = out_rec.frame_ident;
   assign rsp_frame_length = out_rec.frame_length;
   assign rsp_data_out     = out_rec.data_out;
   assign rsp_last         = out_rec.last;
   assign rsp_found        = out_rec.found;

endmodule

`default_nettype wire
